// ===== hw/rtl/bspc_pkg.sv =====
// Shared types and constants for the byte signature protocol classifier.
// Holds the signature table, signature lengths and protocol codes.
// No dependencies.
`timescale 1ns / 1ps

package bspc_pkg;

  // Signature table geometry.
  localparam int TABLE_SIZE    = 11;
  localparam int MAX_SIG_BYTES = 23;
  localparam int SIG_LEN_W     = $clog2(MAX_SIG_BYTES + 1);

  typedef logic [1:0]                   proto_t;
  typedef logic [SIG_LEN_W-1:0]         sig_len_t;
  typedef logic [MAX_SIG_BYTES*8-1:0]   sig_bytes_t;

  // Protocol codes.
  localparam proto_t PROTO_HTTP = 2'd0;
  localparam proto_t PROTO_SSH  = 2'd1;
  localparam proto_t PROTO_FTP  = 2'd2;
  localparam proto_t PROTO_TCP  = 2'd3;

  // Signature text, first character in the most significant byte, so byte k
  // of an entry is the character that sits k positions behind the newest one.
  localparam sig_bytes_t SIG_BYTES [TABLE_SIZE] = '{
    184'h485454502F,
    184'h504F5354202F7375626D69742D666F726D20485454502F,
    184'h2D4F70656E535348,
    184'h55534552,
    184'h4C495354,
    184'h504F5254,
    184'h52455452,
    184'h53544F52,
    184'h435744,
    184'h7373682d7573657261757468,
    184'h7373682D636F6E6E656374696F6E
  };

  localparam sig_len_t SIG_LEN [TABLE_SIZE] = '{
    5'd5, 5'd23, 5'd8, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd3, 5'd12, 5'd14
  };

  localparam proto_t SIG_PROTO [TABLE_SIZE] = '{
    PROTO_HTTP, PROTO_HTTP, PROTO_SSH, PROTO_FTP, PROTO_FTP, PROTO_FTP,
    PROTO_FTP, PROTO_FTP, PROTO_FTP, PROTO_SSH, PROTO_SSH
  };

endpackage

// ===== hw/rtl/bspc_matcher.sv =====
// Parallel signature compare against the byte window ending at the newest byte.
// Uses the signature table from bspc_pkg.
`timescale 1ns / 1ps

module bspc_matcher #(
  parameter int WINDOW_BYTES = 23,
  parameter int SIG_COUNT    = 11,
  parameter int FILL_W       = 5
) (
  input  logic [WINDOW_BYTES-1:0][7:0] window,
  input  logic [FILL_W-1:0]            fill,
  output logic [SIG_COUNT-1:0]         hit
);

  // Per-byte compare results; positions beyond a signature's length always pass.
  logic [bspc_pkg::MAX_SIG_BYTES-1:0] cmp [SIG_COUNT];

  for (genvar s = 0; s < SIG_COUNT; s++) begin : g_sig
    for (genvar k = 0; k < bspc_pkg::MAX_SIG_BYTES; k++) begin : g_byte
      if (k < WINDOW_BYTES) begin : g_in
        assign cmp[s][k] = (k >= int'(bspc_pkg::SIG_LEN[s])) ||
                           (window[k] == bspc_pkg::SIG_BYTES[s][k*8 +: 8]);
      end else begin : g_out
        assign cmp[s][k] = (k >= int'(bspc_pkg::SIG_LEN[s]));
      end
    end

    // A hit needs the whole signature inside valid window bytes.
    assign hit[s] = (&cmp[s]) &&
                    (int'(bspc_pkg::SIG_LEN[s]) <= WINDOW_BYTES) &&
                    (32'(fill) >= 32'(bspc_pkg::SIG_LEN[s]));
  end

endmodule

// ===== hw/rtl/byte_signature_protocol_classifier.sv =====
// The final byte passes the input register stage, then its result beat is registered in the output register.
// Throughput: one byte per cycle; non-final bytes keep flowing while a result
// waits on the output register, a final byte waits only for that register.
// Reset (synchronous, active high) empties both stages and clears window fill,
// found flags and the end-of-string flag. Depends on bspc_pkg, bspc_matcher.
`timescale 1ns / 1ps

module byte_signature_protocol_classifier #(
  parameter int SIGNATURE_COUNT = 11,
  parameter int WINDOW_BYTES    = 23
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] protocol_code,
  output logic [3:0] matched_signature
);

  localparam int ACTIVE = (SIGNATURE_COUNT < bspc_pkg::TABLE_SIZE) ?
                          SIGNATURE_COUNT : bspc_pkg::TABLE_SIZE;
  localparam int FILL_W = $clog2(WINDOW_BYTES + 1);

  // Input register stage.
  logic       a_valid;
  logic [7:0] a_byte;
  logic       a_last;
  logic       a_fire;

  // Message state.
  logic [WINDOW_BYTES-1:0][7:0] window;
  logic [WINDOW_BYTES-1:0][7:0] window_shifted;
  logic [FILL_W-1:0]            fill;
  logic [FILL_W-1:0]            fill_inc;
  logic [ACTIVE-1:0]            found;
  logic [ACTIVE-1:0]            found_next;
  logic [ACTIVE-1:0]            hit;
  logic                         string_ended;
  logic                         take_byte;

  // Result selection.
  bspc_pkg::proto_t proto_sel;
  logic [3:0]       idx_sel;

  // The stage advances unless a final byte finds the output register full.
  assign a_fire   = a_valid && (!a_last || !out_valid || out_ready);
  assign in_ready = !a_valid || a_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      a_byte <= data_byte;
      a_last <= last_byte;
    end
  end

  // Window as it stands after the staged byte is shifted in.
  assign window_shifted = {window[WINDOW_BYTES-2:0], a_byte};
  assign fill_inc = (fill == FILL_W'(WINDOW_BYTES)) ? fill : fill + 1'b1;
  assign take_byte = a_fire && !string_ended && (a_byte != 8'd0);

  bspc_matcher #(
    .WINDOW_BYTES (WINDOW_BYTES),
    .SIG_COUNT    (ACTIVE),
    .FILL_W       (FILL_W)
  ) u_matcher (
    .window (window_shifted),
    .fill   (fill_inc),
    .hit    (hit)
  );

  assign found_next = take_byte ? (found | hit) : found;

  // Lowest-index found signature wins.
  always_comb begin
    proto_sel = bspc_pkg::PROTO_TCP;
    idx_sel   = 4'(ACTIVE);
    for (int s = ACTIVE - 1; s >= 0; s--) begin
      if (found_next[s]) begin
        proto_sel = bspc_pkg::SIG_PROTO[s];
        idx_sel   = 4'(s);
      end
    end
  end

  // Window payload needs no reset: the fill count masks stale bytes.
  always_ff @(posedge clk) begin
    if (take_byte) begin
      window <= window_shifted;
    end
  end

  // Message state update; a final byte clears it for the next message.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill         <= '0;
      found        <= '0;
      string_ended <= 1'b0;
    end else if (a_fire) begin
      if (a_last) begin
        fill         <= '0;
        found        <= '0;
        string_ended <= 1'b0;
      end else begin
        found <= found_next;
        if (take_byte) begin
          fill <= fill_inc;
        end
        if (!string_ended && (a_byte == 8'd0)) begin
          string_ended <= 1'b1;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_fire && a_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (a_fire && a_last) begin
      protocol_code     <= proto_sel;
      matched_signature <= idx_sel;
    end
  end

  // The fill count never passes the window depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fill) <= WINDOW_BYTES)
    else $error("window fill exceeds window depth");

  // No-match index and the TCP code always travel together.
  a_tcp_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((matched_signature == 4'(ACTIVE)) ==
                   (protocol_code == bspc_pkg::PROTO_TCP)))
    else $error("no-match index and protocol code disagree");

  // A final beat leaves the message state clear.
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (a_fire && a_last) |=> (fill == '0) && (found == '0) && !string_ended)
    else $error("state not cleared after final byte");

  // Found flags only accumulate within a message.
  a_flags_grow: assert property (@(posedge clk) disable iff (rst)
    !(a_fire && a_last) |=> (($past(found) & ~found) == '0))
    else $error("found flag dropped within a message");

  // After the string ends, nothing more enters the window or the flags.
  a_ended_frozen: assert property (@(posedge clk) disable iff (rst)
    (string_ended && !(a_fire && a_last)) |=> $stable(fill) && $stable(found))
    else $error("state changed after end of string");

endmodule

// ===== verif/tb_byte_signature_protocol_classifier.sv =====
// Self-checking testbench for byte_signature_protocol_classifier.
// Streams messages of payload bytes, predicts each message verdict and checks it.
// Depends on bspc_pkg and the classifier RTL.
`timescale 1ns / 1ps

module tb_byte_signature_protocol_classifier;

  localparam int SIG_NUM     = 11;
  localparam int WIN_BYTES   = 23;
  localparam int LIMIT       = 200000;
  localparam int CALM_FROM   = 100;
  localparam int CALM_TO     = 300;
  localparam int HOLD_AT     = 350;
  localparam int HOLD_CYCLES = 60;

  typedef struct packed {
    bspc_pkg::proto_t proto;
    logic [3:0]       sig_id;
  } verdict_t;

  // Keeps its own copy of the matcher state and the verdicts still owed.
  class signature_scoreboard;
    string            sig_text [SIG_NUM];
    bspc_pkg::proto_t sig_proto[SIG_NUM];
    logic [7:0]       window   [WIN_BYTES];
    int               fill;
    logic [SIG_NUM-1:0] found;
    bit               ended;
    verdict_t         verdict_q[$];
    int               errors;
    int               mismatches;

    function new();
      sig_text = '{"HTTP/", "POST /submit-form HTTP/", "-OpenSSH", "USER", "LIST",
                   "PORT", "RETR", "STOR", "CWD", "ssh-userauth", "ssh-connection"};
      sig_proto = '{bspc_pkg::PROTO_HTTP, bspc_pkg::PROTO_HTTP, bspc_pkg::PROTO_SSH,
                    bspc_pkg::PROTO_FTP, bspc_pkg::PROTO_FTP, bspc_pkg::PROTO_FTP,
                    bspc_pkg::PROTO_FTP, bspc_pkg::PROTO_FTP, bspc_pkg::PROTO_FTP,
                    bspc_pkg::PROTO_SSH, bspc_pkg::PROTO_SSH};
      errors = 0;
      mismatches = 0;
      clear_message();
    endfunction

    function void clear_message();
      foreach (window[k]) window[k] = 8'h00;
      fill  = 0;
      found = '0;
      ended = 1'b0;
    endfunction

    function void flag_error(string msg);
      errors++;
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] mismatch: %s", $time, msg);
      end
    endfunction

    // Notes one accepted input beat and, on the final byte, the verdict it owes.
    function void note_byte(logic [7:0] b, logic last);
      int       len;
      bit       hit;
      verdict_t v;
      if (!ended) begin
        if (b == 8'h00) begin
          ended = 1'b1;
        end else begin
          for (int k = WIN_BYTES - 1; k > 0; k--) window[k] = window[k-1];
          window[0] = b;
          if (fill < WIN_BYTES) fill++;
          for (int s = 0; s < SIG_NUM; s++) begin
            len = sig_text[s].len();
            if (len <= WIN_BYTES && len <= fill) begin
              hit = 1'b1;
              for (int k = 0; k < len; k++) begin
                if (sig_text[s][len-1-k] != window[k]) hit = 1'b0;
              end
              if (hit) found[s] = 1'b1;
            end
          end
        end
      end
      if (last) begin
        v.proto  = bspc_pkg::PROTO_TCP;
        v.sig_id = 4'(SIG_NUM);
        for (int s = SIG_NUM - 1; s >= 0; s--) begin
          if (found[s]) begin
            v.proto  = sig_proto[s];
            v.sig_id = 4'(s);
          end
        end
        verdict_q.push_back(v);
        clear_message();
      end
    endfunction

    // Compares one result beat with the oldest verdict owed.
    function void check_result(bspc_pkg::proto_t proto, logic [3:0] sig_id);
      verdict_t v;
      if (verdict_q.size() == 0) begin
        flag_error($sformatf("unexpected result protocol %0d signature %0d", proto, sig_id));
        return;
      end
      v = verdict_q.pop_front();
      if (proto !== v.proto) begin
        flag_error($sformatf("protocol_code expected %0d actual %0d", v.proto, proto));
      end
      if (sig_id !== v.sig_id) begin
        flag_error($sformatf("matched_signature expected %0d actual %0d", v.sig_id, sig_id));
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       data_byte = 8'h00;
  logic             last_byte = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  bspc_pkg::proto_t protocol_code;
  logic [3:0]       matched_signature;

  int         cycle = 0;
  int         hold_left = 0;
  logic [7:0] frame_q[$];

  signature_scoreboard sb = new();

  byte_signature_protocol_classifier dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .data_byte        (data_byte),
    .last_byte        (last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .protocol_code    (protocol_code),
    .matched_signature(matched_signature)
  );

  // Free-running clock.
  initial begin
    forever #1 clk = ~clk;
  end

  // Cycle count and run watchdog.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic bit calm();
    return cycle >= CALM_FROM && cycle < CALM_TO;
  endfunction

  // Receiver: random back-pressure plus one long hold so the block fills up.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (cycle == HOLD_AT) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_ready <= calm() || ($urandom_range(99) >= 22);
    end
  end

  // Accepted input beats feed the predictor.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      sb.note_byte(data_byte, last_byte);
    end
  end

  // Accepted result beats are checked.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result(protocol_code, matched_signature);
    end
  end

  // Offers one beat, idling first at random, and returns at the accepting edge.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!calm() && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  function automatic void push_text(string txt);
    for (int i = 0; i < txt.len(); i++) frame_q.push_back(txt[i]);
  endfunction

  // Builds one random message: mostly signatures, damaged signatures and
  // filler, with some pure noise messages and early string ends.
  function automatic void compose_frame();
    int    segs;
    int    idx;
    int    cut;
    string txt;
    frame_q.delete();
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(1, 30)) frame_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      segs = $urandom_range(1, 3);
      for (int n = 0; n < segs; n++) begin
        idx = $urandom_range(0, SIG_NUM - 1);
        txt = sb.sig_text[idx];
        case ($urandom_range(0, 5))
          0, 1, 2: begin
            push_text(txt);
          end
          3: begin
            // One character changed, often only in case.
            cut = $urandom_range(0, txt.len() - 1);
            for (int i = 0; i < txt.len(); i++) begin
              if (i != cut) begin
                frame_q.push_back(txt[i]);
              end else if ($urandom_range(1)) begin
                frame_q.push_back(txt[i] ^ 8'h20);
              end else begin
                frame_q.push_back(8'($urandom_range(1, 255)));
              end
            end
          end
          4: begin
            // Truncated signature, either its head or its tail.
            cut = $urandom_range(1, txt.len() - 1);
            if ($urandom_range(1)) begin
              push_text(txt.substr(0, cut - 1));
            end else begin
              push_text(txt.substr(cut, txt.len() - 1));
            end
          end
          default: begin
            repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom_range(1, 255)));
          end
        endcase
        if ($urandom_range(99) < 8) frame_q.push_back(8'h00);
      end
      if ($urandom_range(99) < 10) frame_q.push_back(8'h00);
    end
  endfunction

  // Reset, directed messages, random messages, then drain.
  initial begin
    int fed_bytes;
    int frames;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty message: a lone zero byte that is also the last.
    frame_q = '{8'h00};
    send_frame();
    // Single all-ones byte.
    frame_q = '{8'hFF};
    send_frame();
    // Shortest signature alone.
    frame_q.delete();
    push_text("CWD");
    send_frame();
    // A signature after the string end must be ignored.
    frame_q.delete();
    push_text("ab");
    frame_q.push_back(8'h00);
    push_text("USER");
    send_frame();
    // Zero byte carrying the last flag still reports what was found.
    frame_q.delete();
    push_text("LIST");
    frame_q.push_back(8'h00);
    send_frame();
    // A signature split across two messages must not match.
    frame_q.delete();
    push_text("HTT");
    send_frame();
    frame_q.delete();
    push_text("P/");
    send_frame();

    fed_bytes = 0;
    frames = 0;
    while (fed_bytes < 450 || frames < 40) begin
      compose_frame();
      send_frame();
      fed_bytes += frame_q.size();
      frames++;
    end
    in_valid <= 1'b0;

    // Let the final accepted beat reach the predictor before draining.
    @(posedge clk);
    while (sb.verdict_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.verdict_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
